// ----- rtl/core/sorted_set_insert_delete_macros.svh -----
// Assertion macros shared by the checker of the sorted set block.
// Include this file by its bare name; it depends on nothing else.
`ifndef SORTED_SET_INSERT_DELETE_MACROS_SVH
`define SORTED_SET_INSERT_DELETE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SSID_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sorted set check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SSID_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorted set check failed");

`endif

// ----- rtl/core/ssid_pkg.sv -----
// Shared types and constants of the sorted set insert/delete block.
// Depends on nothing; the cell, encoder, top and checker files refer to it by scoped names.
`default_nettype none

package ssid_pkg;

    // Store geometry.
    localparam int CAPACITY  = 64;
    localparam int ROW_WIDTH = 4;
    localparam int VALUE_W   = 32;
    localparam int POS_W     = 6;
    localparam int COUNT_W   = 7;
    localparam int ROW_W     = 4;
    localparam int COL_W     = 2;
    localparam int STATUS_W  = 3;

    // Command codes.
    typedef enum logic {
        ACT_INSERT = 1'b0,
        ACT_DELETE = 1'b1
    } action_t;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED  = 3'd0,
        ST_DELETED   = 3'd1,
        ST_DUPLICATE = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_FULL      = 3'd4
    } status_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_UPD
    } state_t;

    // Control broadcast from the sequencer to every cell.
    typedef struct packed {
        logic cmp_en;
        logic shift_ins;
        logic shift_del;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/core/ssid_cell.sv -----
// One storage cell of the sorted row: holds one value and its compare flags.
// Depends on ssid_pkg for widths and the control struct.
`default_nettype none

module ssid_cell (
    input  wire logic                              clk,
    input  wire ssid_pkg::cell_ctrl_t              ctrl,
    input  wire logic signed [ssid_pkg::VALUE_W-1:0] key,
    input  wire logic                              occupied,
    input  wire logic                              left_lt,
    input  wire logic        [ssid_pkg::VALUE_W-1:0] left_value,
    input  wire logic        [ssid_pkg::VALUE_W-1:0] right_value,
    output logic             [ssid_pkg::VALUE_W-1:0] value,
    output logic                                   lt,
    output logic                                   eq
);

    logic [ssid_pkg::VALUE_W-1:0] value_reg;
    logic [ssid_pkg::VALUE_W-1:0] value_next;
    logic                         lt_reg;
    logic                         lt_next;
    logic                         eq_reg;
    logic                         eq_next;

    // Compare the broadcast key against the held value during the compare cycle.
    always_comb
    begin
        lt_next = lt_reg;
        eq_next = eq_reg;
        if (ctrl.cmp_en)
        begin
            lt_next = occupied && ($signed(value_reg) < key);
            eq_next = occupied && (value_reg == key);
        end
    end

    // Cells at or above the sorted position shift; on an insert the one at the position takes the key.
    always_comb
    begin
        value_next = value_reg;
        if (ctrl.shift_ins && !lt_reg)
        begin
            value_next = left_lt ? key : left_value;
        end
        else if (ctrl.shift_del && !lt_reg)
        begin
            value_next = right_value;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        lt_reg    <= lt_next;
        eq_reg    <= eq_next;
    end

    assign value = value_reg;
    assign lt    = lt_reg;
    assign eq    = eq_reg;

endmodule

`default_nettype wire

// ----- rtl/core/ssid_encode.sv -----
// Turns the thermometer of below-key flags from the cell row into a position.
// Depends on ssid_pkg for the store size and widths.
`default_nettype none

module ssid_encode (
    input  wire logic [ssid_pkg::CAPACITY-1:0] lt_flags,
    output logic      [ssid_pkg::COUNT_W-1:0]  pos
);

    // The flags form a run of ones from cell zero; mark its end and OR-encode it.
    always_comb
    begin
        logic edge_bit;
        pos = '0;
        for (int i = 0; i <= ssid_pkg::CAPACITY; i++)
        begin
            if (i == 0)
            begin
                edge_bit = !lt_flags[0];
            end
            else if (i == ssid_pkg::CAPACITY)
            begin
                edge_bit = lt_flags[ssid_pkg::CAPACITY-1];
            end
            else
            begin
                edge_bit = lt_flags[i-1] && !lt_flags[i];
            end
            if (edge_bit)
            begin
                pos = pos | ssid_pkg::COUNT_W'(i);
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/sorted_set_insert_delete.sv -----
// Each command passes through an accept state, a compare state across the cell row, then
// an update state in which every cell shifts in from a neighbour or holds, and in which
// the result is loaded. A new command is taken only after the update, back in idle.
// The update cycle waits while an earlier result is still held unaccepted.
// Reset clears the held count, the sequencer and the result valid flag; the stored
// values are left undefined and are never read above the held count.
`default_nettype none

module sorted_set_insert_delete (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cmd_valid,
    output logic                                   cmd_ready,
    input  wire logic                              action,
    input  wire logic signed [ssid_pkg::VALUE_W-1:0] key_value,
    output logic                                   rsp_valid,
    input  wire logic                              rsp_ready,
    output logic             [ssid_pkg::STATUS_W-1:0] status,
    output logic             [ssid_pkg::POS_W-1:0]   position,
    output logic             [ssid_pkg::ROW_W-1:0]   row_index,
    output logic             [ssid_pkg::COL_W-1:0]   column_index,
    output logic             [ssid_pkg::COUNT_W-1:0] entry_count
);

    ssid_pkg::state_t                      state_reg;
    ssid_pkg::state_t                      state_next;
    logic [ssid_pkg::COUNT_W-1:0]          count_reg;
    logic [ssid_pkg::COUNT_W-1:0]          count_next;
    logic signed [ssid_pkg::VALUE_W-1:0]   key_reg;
    logic signed [ssid_pkg::VALUE_W-1:0]   key_next;
    ssid_pkg::action_t                     action_reg;
    ssid_pkg::action_t                     action_next;
    logic                                  rsp_valid_reg;
    logic                                  rsp_valid_next;
    ssid_pkg::status_t                     status_reg;
    ssid_pkg::status_t                     status_next;
    logic [ssid_pkg::POS_W-1:0]            position_reg;
    logic [ssid_pkg::POS_W-1:0]            position_next;
    logic [ssid_pkg::COUNT_W-1:0]          entry_count_reg;
    logic [ssid_pkg::COUNT_W-1:0]          entry_count_next;

    ssid_pkg::cell_ctrl_t                  cell_ctrl;
    logic [ssid_pkg::CAPACITY-1:0]         lt_flags;
    logic [ssid_pkg::CAPACITY-1:0]         eq_flags;
    logic [ssid_pkg::CAPACITY-1:0]         occupied;
    logic [ssid_pkg::VALUE_W-1:0]          cell_value [ssid_pkg::CAPACITY];
    logic [ssid_pkg::COUNT_W-1:0]          sorted_pos;
    logic                                  hit;
    logic                                  rsp_free;

    // The row of cells, inner cells wired to both neighbours; the first reads the key on its left.
    for (genvar i = 0; i < ssid_pkg::CAPACITY; i++)
    begin : g_cell
        logic                         left_lt;
        logic [ssid_pkg::VALUE_W-1:0] left_value;
        logic [ssid_pkg::VALUE_W-1:0] right_value;

        if (i == 0)
        begin : g_first
            assign left_lt    = 1'b1;
            assign left_value = key_reg;
        end
        else
        begin : g_inner_left
            assign left_lt    = lt_flags[i-1];
            assign left_value = cell_value[i-1];
        end

        if (i == ssid_pkg::CAPACITY - 1)
        begin : g_last
            assign right_value = cell_value[i];
        end
        else
        begin : g_inner_right
            assign right_value = cell_value[i+1];
        end

        assign occupied[i] = ssid_pkg::COUNT_W'(i) < count_reg;

        ssid_cell u_cell (
            .clk         (clk),
            .ctrl        (cell_ctrl),
            .key         (key_reg),
            .occupied    (occupied[i]),
            .left_lt     (left_lt),
            .left_value  (left_value),
            .right_value (right_value),
            .value       (cell_value[i]),
            .lt          (lt_flags[i]),
            .eq          (eq_flags[i])
        );
    end

    // Sorted position from the registered compare flags.
    ssid_encode u_encode (
        .lt_flags (lt_flags),
        .pos      (sorted_pos)
    );

    assign hit      = |eq_flags;
    assign rsp_free = !rsp_valid_reg || rsp_ready;

    // Sequencer: accept, compare, then update the row and load the result.
    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        key_next         = key_reg;
        action_next      = action_reg;
        rsp_valid_next   = rsp_valid_reg && !rsp_ready;
        status_next      = status_reg;
        position_next    = position_reg;
        entry_count_next = entry_count_reg;
        cell_ctrl        = '0;
        cmd_ready        = 1'b0;

        case (state_reg)
            ssid_pkg::S_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    key_next    = key_value;
                    action_next = ssid_pkg::action_t'(action);
                    state_next  = ssid_pkg::S_CMP;
                end
            end
            ssid_pkg::S_CMP:
            begin
                cell_ctrl.cmp_en = 1'b1;
                state_next       = ssid_pkg::S_UPD;
            end
            ssid_pkg::S_UPD:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next = 1'b1;
                    position_next  = '0;
                    if (action_reg == ssid_pkg::ACT_INSERT)
                    begin
                        if (hit)
                        begin
                            status_next   = ssid_pkg::ST_DUPLICATE;
                            position_next = sorted_pos[ssid_pkg::POS_W-1:0];
                        end
                        else if (count_reg == ssid_pkg::COUNT_W'(ssid_pkg::CAPACITY))
                        begin
                            status_next = ssid_pkg::ST_FULL;
                        end
                        else
                        begin
                            status_next         = ssid_pkg::ST_INSERTED;
                            position_next       = sorted_pos[ssid_pkg::POS_W-1:0];
                            cell_ctrl.shift_ins = 1'b1;
                            count_next          = count_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        if (hit)
                        begin
                            status_next         = ssid_pkg::ST_DELETED;
                            position_next       = sorted_pos[ssid_pkg::POS_W-1:0];
                            cell_ctrl.shift_del = 1'b1;
                            count_next          = count_reg - 1'b1;
                        end
                        else
                        begin
                            status_next = ssid_pkg::ST_NOT_FOUND;
                        end
                    end
                    entry_count_next = count_next;
                    state_next       = ssid_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ssid_pkg::S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ssid_pkg::S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Command and result payload registers.
    always_ff @(posedge clk)
    begin
        key_reg         <= key_next;
        action_reg      <= action_next;
        status_reg      <= status_next;
        position_reg    <= position_next;
        entry_count_reg <= entry_count_next;
    end

    assign rsp_valid    = rsp_valid_reg;
    assign status       = status_reg;
    assign position     = position_reg;
    assign row_index    = ssid_pkg::ROW_W'(position_reg / ssid_pkg::ROW_WIDTH);
    assign column_index = ssid_pkg::COL_W'(position_reg % ssid_pkg::ROW_WIDTH);
    assign entry_count  = entry_count_reg;

endmodule

`default_nettype wire

// ----- rtl/core/ssid_checker.sv -----
// Port-level checks on the sorted set block, attached to it by a bind statement.
// Depends on ssid_pkg and on the assertion macros header.
`default_nettype none
`include "sorted_set_insert_delete_macros.svh"

module ssid_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              cmd_valid,
    input wire logic                              cmd_ready,
    input wire logic                              rsp_valid,
    input wire logic                              rsp_ready,
    input wire logic [ssid_pkg::STATUS_W-1:0]     status,
    input wire logic [ssid_pkg::POS_W-1:0]        position,
    input wire logic [ssid_pkg::ROW_W-1:0]        row_index,
    input wire logic [ssid_pkg::COL_W-1:0]        column_index,
    input wire logic [ssid_pkg::COUNT_W-1:0]      entry_count
);

    // A stalled result keeps its contents.
    `SSID_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(status) && $stable(position) && $stable(entry_count))

    // Only one command is in flight: ready drops after each transfer.
    `SSID_ASSERT_NEXT(a_one_in_flight, clk, rst_n, cmd_valid && cmd_ready, !cmd_ready)

    // Row and column always split the reported position.
    `SSID_ASSERT_NOW(a_row_col, clk, rst_n, rsp_valid, {row_index, column_index} == position)

    // A refused insert only happens with a full store and reports position zero.
    `SSID_ASSERT_NOW(a_full, clk, rst_n, rsp_valid && (status == ssid_pkg::ST_FULL), (entry_count == ssid_pkg::COUNT_W'(ssid_pkg::CAPACITY)) && (position == '0))

endmodule

bind sorted_set_insert_delete ssid_checker u_ssid_checker (.*);

`default_nettype wire
